### design/assert_macros.svh
// Assertion macros shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Holds at every rising edge of clk outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// The expression is never true at a rising edge of clk outside reset.
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

### design/cpfr_pkg.sv
package cpfr_pkg;

  localparam int NUM_FRAMES = 64;
  localparam int PAGE_BITS  = 20;
  localparam int OWNER_BITS = 8;
  localparam int FRAME_BITS = $clog2(NUM_FRAMES);
  localparam int CNT_BITS   = FRAME_BITS + 1;
  localparam int CFG_BITS   = 7;

  localparam logic [CFG_BITS-1:0] CFG_RESET = CFG_BITS'(64);

  typedef logic [FRAME_BITS-1:0] frame_idx_t;
  typedef logic [CNT_BITS-1:0]   frame_cnt_t;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_FREE   = 2'd1,
    OP_ACCESS = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef struct packed {
    logic                  referenced;
    logic                  dirty;
    logic                  stack;
    logic [PAGE_BITS-1:0]  page;
    logic [OWNER_BITS-1:0] owner;
  } frame_entry_t;

  typedef struct packed {
    logic         en;
    frame_idx_t   addr;
    frame_entry_t data;
  } ram_wr_t;

  function automatic frame_cnt_t active_count(logic [CFG_BITS-1:0] cfg);
    frame_cnt_t n;
    if (cfg == '0) begin
      n = CNT_BITS'(1);
    end else if (int'(cfg) > NUM_FRAMES) begin
      n = CNT_BITS'(NUM_FRAMES);
    end else begin
      n = CNT_BITS'(cfg);
    end
    return n;
  endfunction

  function automatic frame_idx_t next_slot(frame_idx_t pos, frame_cnt_t n);
    frame_cnt_t p1;
    p1 = {1'b0, pos} + CNT_BITS'(1);
    return (p1 >= n) ? '0 : p1[FRAME_BITS-1:0];
  endfunction

endpackage

### design/cpfr_frame_ram.sv
module cpfr_frame_ram (
  input  logic                   clk,
  input  cpfr_pkg::ram_wr_t      wr,
  input  cpfr_pkg::frame_idx_t   rd_addr,
  output cpfr_pkg::frame_entry_t rd_data
);

  cpfr_pkg::frame_entry_t mem [cpfr_pkg::NUM_FRAMES];
  cpfr_pkg::frame_entry_t ram_q;
  cpfr_pkg::frame_entry_t fwd_q;
  logic                   fwd_hit;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    ram_q   <= mem[rd_addr];
    fwd_q   <= wr.data;
    fwd_hit <= wr.en && (wr.addr == rd_addr);
  end

  // A read of the entry written in the same cycle returns the new data.
  assign rd_data = fwd_hit ? fwd_q : ram_q;

endmodule

### design/clock_page_frame_replacer_core.sv
// Clock (second-chance) page frame replacer. A beat on the input channel is
// taken only while the block is idle, and each beat yields exactly one result
// beat. Free, access and unused opcodes are evaluated in the EVAL state and
// put their result out once the output register is free; the block then
// returns to idle. An insert stays in EVAL while the hand passes over valid
// referenced frames, clearing each referenced mark, so it passes over at most
// n frames, where n is the active frame count after limiting to 1..64.
// The walk does one read-modify-write of the frame memory per cycle, with
// the read data of the next frame forwarded when it is the entry just
// written. Valid marks are flip-flops cleared by reset, so no clearing pass
// is needed. A finished result waits in the output register while the next
// beat is accepted. A result that is still stalled when the next one is
// ready holds the block until it is taken.
`include "assert_macros.svh"

module clock_page_frame_replacer_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [cpfr_pkg::CFG_BITS-1:0]        cfg_wr_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           opcode,
  input  logic [cpfr_pkg::PAGE_BITS-1:0]       page_number,
  input  logic [cpfr_pkg::OWNER_BITS-1:0]      owner_id,
  input  logic                                 is_stack,
  input  logic [cpfr_pkg::FRAME_BITS-1:0]      target_frame,
  input  logic                                 is_write,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [cpfr_pkg::FRAME_BITS-1:0]      chosen_frame,
  output logic                                 did_evict,
  output logic [cpfr_pkg::PAGE_BITS-1:0]       evicted_page,
  output logic [cpfr_pkg::OWNER_BITS-1:0]      evicted_owner,
  output logic                                 swap_out,
  output logic                                 status
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EVAL = 2'b10
  } state_t;

  state_t                                state;
  state_t                                state_next;
  logic [cpfr_pkg::CFG_BITS-1:0]         active_frames;
  cpfr_pkg::frame_idx_t                  hand;
  logic [cpfr_pkg::NUM_FRAMES-1:0]       frame_valid;
  cpfr_pkg::frame_idx_t                  pos;
  cpfr_pkg::op_t                         op;
  logic [cpfr_pkg::PAGE_BITS-1:0]        page_q;
  logic [cpfr_pkg::OWNER_BITS-1:0]       owner_q;
  logic                                  stack_q;
  logic                                  write_q;

  cpfr_pkg::frame_cnt_t                  n;
  cpfr_pkg::frame_idx_t                  start_pos;
  cpfr_pkg::frame_idx_t                  nxt;
  cpfr_pkg::frame_idx_t                  rd_addr;
  cpfr_pkg::frame_entry_t                entry;
  cpfr_pkg::ram_wr_t                     ram_wr;
  logic                                  in_accept;
  logic                                  out_free;
  logic                                  pos_valid;
  logic                                  skip;
  logic                                  commit;
  logic                                  bad_target;

  assign n          = cpfr_pkg::active_count(active_frames);
  assign start_pos  = ({1'b0, hand} >= n) ? '0 : hand;
  assign nxt        = cpfr_pkg::next_slot(pos, n);
  assign in_stall   = (state != ST_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign out_free   = !out_valid || !out_stall;
  assign pos_valid  = frame_valid[pos];
  assign skip       = (state == ST_EVAL) && (op == cpfr_pkg::OP_INSERT)
                      && pos_valid && entry.referenced;
  assign commit     = (state == ST_EVAL) && !skip && out_free;
  assign bad_target = (op == cpfr_pkg::OP_NONE) || ({1'b0, pos} >= n) || !pos_valid;

  cpfr_frame_ram u_ram (
    .clk     (clk),
    .wr      (ram_wr),
    .rd_addr (rd_addr),
    .rd_data (entry)
  );

  always_comb begin
    state_next     = state;
    rd_addr        = pos;
    ram_wr.en      = 1'b0;
    ram_wr.addr    = pos;
    ram_wr.data    = entry;
    unique case (state)
      ST_IDLE: begin
        rd_addr = (cpfr_pkg::op_t'(opcode) == cpfr_pkg::OP_INSERT) ? start_pos : target_frame;
        if (in_accept) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (skip) begin
          ram_wr.en              = 1'b1;
          ram_wr.data.referenced = 1'b0;
          rd_addr                = nxt;
        end else if (commit) begin
          state_next = ST_IDLE;
          if (op == cpfr_pkg::OP_INSERT) begin
            ram_wr.en              = 1'b1;
            ram_wr.data.referenced = 1'b1;
            ram_wr.data.dirty      = 1'b0;
            ram_wr.data.stack      = stack_q;
            ram_wr.data.page       = page_q;
            ram_wr.data.owner      = owner_q;
          end else if (op == cpfr_pkg::OP_ACCESS && !bad_target) begin
            ram_wr.en              = 1'b1;
            ram_wr.data.referenced = 1'b1;
            ram_wr.data.dirty      = entry.dirty | write_q;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      active_frames <= cpfr_pkg::CFG_RESET;
      hand          <= '0;
      frame_valid   <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        active_frames <= cfg_wr_data;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (commit) begin
        out_valid <= 1'b1;
        if (op == cpfr_pkg::OP_INSERT) begin
          frame_valid[pos] <= 1'b1;
          hand             <= nxt;
        end else if (op == cpfr_pkg::OP_FREE && !bad_target) begin
          frame_valid[pos] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op      <= cpfr_pkg::op_t'(opcode);
      page_q  <= page_number;
      owner_q <= owner_id;
      stack_q <= is_stack;
      write_q <= is_write;
      pos     <= (cpfr_pkg::op_t'(opcode) == cpfr_pkg::OP_INSERT) ? start_pos : target_frame;
    end else if (skip) begin
      pos <= nxt;
    end
    if (commit) begin
      chosen_frame <= pos;
      if (op == cpfr_pkg::OP_INSERT) begin
        did_evict     <= pos_valid;
        evicted_page  <= pos_valid ? entry.page : '0;
        evicted_owner <= pos_valid ? entry.owner : '0;
        swap_out      <= pos_valid && (entry.dirty || entry.stack);
        status        <= 1'b0;
      end else begin
        did_evict     <= 1'b0;
        evicted_page  <= '0;
        evicted_owner <= '0;
        swap_out      <= 1'b0;
        status        <= bad_target;
      end
    end
  end

  `ASSERT_CLK(a_accept_to_eval, in_accept |=> (state == ST_EVAL), "accepted beat not evaluated")
  `ASSERT_CLK(a_hand_in_range, (commit && op == cpfr_pkg::OP_INSERT) |=> ({1'b0, hand} < n),
              "hand outside active frames after insert")
  `ASSERT_NEVER(a_ram_write_idle, ram_wr.en && state != ST_EVAL, "frame memory written while idle")
  `ASSERT_CLK(a_result_held, (out_valid && out_stall) |=> out_valid, "stalled result dropped")

endmodule
